>>> hw/rtl/msbc_pkg.sv
// Package for the mode-select byte checksum unit.
// Holds mode codes, register map constants and the ones'-complement add.
// No dependencies.
package msbc_pkg;

	localparam int unsigned DataW    = 8;
	localparam int unsigned SumW     = 16;
	localparam int unsigned ModeW    = 2;
	localparam int unsigned SizeW    = 2;
	localparam int unsigned CfgAddrW = 2;
	localparam int unsigned CfgDataW = 32;

	localparam logic [ModeW-1:0] MODE_NONE  = 2'd0;
	localparam logic [ModeW-1:0] MODE_SUM16 = 2'd1;
	localparam logic [ModeW-1:0] MODE_XOR8  = 2'd2;

	localparam logic [CfgAddrW-1:0] REG_MODE_ADDR = 2'd0;

	localparam logic [SizeW-1:0] SIZE_NONE  = 2'd0;
	localparam logic [SizeW-1:0] SIZE_XOR8  = 2'd1;
	localparam logic [SizeW-1:0] SIZE_SUM16 = 2'd2;

	localparam logic [SumW-1:0] PAD_LOW = 16'h00FF;

	typedef logic [SumW-1:0] sum_t;

	// 16-bit add with end-around carry
	function automatic sum_t oc_add(input sum_t a, input sum_t b);
		logic [SumW:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			oc_add = s[SumW-1:0] + {{(SumW-1){1'b0}}, s[SumW]};
		end
	endfunction

endpackage

>>> hw/rtl/msbc_if.sv
// Valid/ready channel interfaces for the checksum unit.
// Depends on msbc_pkg for field widths.
interface msbc_in_if import msbc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DataW-1:0] data_byte;
	logic             last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface msbc_out_if import msbc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SumW-1:0]  checksum_value;
	logic [SizeW-1:0] checksum_bytes;

	modport source (output valid, output checksum_value, output checksum_bytes, input ready);
	modport sink (input valid, input checksum_value, input checksum_bytes, output ready);
endinterface

>>> hw/rtl/mode_select_byte_checksum_unit.sv
// Mode-select byte checksum unit: sum16, xor8 or none over a byte stream.
// A last byte passes stage 1, then the output register; it waits in stage 1 for a free output slot.
// Throughput: one byte per cycle unless a last byte waits in stage 1, set by the single sum/xor update stage.
// Non-last bytes keep flowing while a result waits; a last byte holds until it drains.
// Reset (arst_n low, asynchronous) clears mode, running sum/xor and valids.
// Depends on msbc_pkg and msbc_if.
module mode_select_byte_checksum_unit
	import msbc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	msbc_in_if.sink             byte_in,
	msbc_out_if.source          result_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready
);

	logic [ModeW-1:0] mode_q;
	logic             valid_s1;
	logic [DataW-1:0] data_s1;
	logic             last_s1;
	sum_t             sum_q;
	logic [DataW-1:0] xor_q;
	logic             expect_high_q;
	logic             out_valid_q;
	sum_t             value_q;
	logic [SizeW-1:0] bytes_q;

	logic             adv_s1;
	logic             emit_s1;
	sum_t             contrib;
	sum_t             sum_word;
	sum_t             sum_final;
	logic [DataW-1:0] xor_next;
	sum_t             value_d;
	logic [SizeW-1:0] bytes_d;
	logic             cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_MODE_ADDR);
	assign prdata = (paddr == REG_MODE_ADDR) ? {{(CfgDataW-ModeW){1'b0}}, mode_q}
	                                         : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
		end else if (cfg_wr) begin
			mode_q <= pwdata[ModeW-1:0];
		end
	end

	// A non-last byte needs no output slot; a last byte waits for a free one
	assign emit_s1       = valid_s1 && last_s1;
	assign adv_s1        = valid_s1 && (!last_s1 || !out_valid_q || result_out.ready);
	assign byte_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			data_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last_byte;
		end
	end

	// Sum and xor update for the byte in stage 1
	always_comb begin
		contrib   = expect_high_q ? {~data_s1, {DataW{1'b0}}} : {{DataW{1'b0}}, ~data_s1};
		sum_word  = oc_add(sum_q, contrib);
		// pad an odd final byte with a complemented zero low byte
		sum_final = expect_high_q ? oc_add(sum_word, PAD_LOW) : sum_word;
		xor_next  = xor_q ^ data_s1;
	end

	always_comb begin
		case (mode_q)
			MODE_SUM16: begin
				value_d = sum_final;
				bytes_d = SIZE_SUM16;
			end
			MODE_XOR8: begin
				value_d = {{(SumW-DataW){1'b0}}, xor_next};
				bytes_d = SIZE_XOR8;
			end
			default: begin
				value_d = '0;
				bytes_d = SIZE_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q         <= '0;
			xor_q         <= '0;
			expect_high_q <= 1'b1;
		end else if (adv_s1) begin
			if (last_s1) begin
				sum_q         <= '0;
				xor_q         <= '0;
				expect_high_q <= 1'b1;
			end else begin
				sum_q         <= sum_word;
				xor_q         <= xor_next;
				expect_high_q <= !expect_high_q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			value_q <= value_d;
			bytes_q <= bytes_d;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.checksum_value = value_q;
	assign result_out.checksum_bytes = bytes_q;

`ifndef NO_ASSERTIONS
	// A new result only follows a last byte leaving stage 1
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(valid_s1 && last_s1))
		else $error("result without a last byte");

	// Message state is clear after a last byte
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && emit_s1) |=> (sum_q == '0 && xor_q == '0 && expect_high_q))
		else $error("message state not cleared");

	// A last byte never overwrites an undelivered result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_out.ready) |-> !(adv_s1 && emit_s1))
		else $error("pending result overwritten");

	// Size code agrees with value shape
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bytes_q == SIZE_NONE) |-> (value_q == '0))
		else $error("no-checksum result not zero");

	a_xor_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bytes_q == SIZE_XOR8) |-> (value_q[SumW-1:DataW] == '0))
		else $error("xor8 result has high bits set");
`endif

endmodule

>>> tb/sv/msbc_checker.sv
// Checker for the mode-select byte checksum unit: follows the byte and result
// channels and the register port, predicts each checksum and compares it.
// Depends on msbc_pkg and the channel interfaces in msbc_if.
module msbc_checker
	import msbc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	msbc_in_if                  byte_ch,
	msbc_out_if                 result_ch,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output int                  mismatches,
	output int                  pending,
	output int                  results_checked
);

	localparam int MaxReports = 10;

	typedef struct packed {
		logic [SumW-1:0]  value;
		logic [SizeW-1:0] bytes;
	} checksum_t;

	checksum_t        expected_checksums[$];
	logic [ModeW-1:0] mode;
	sum_t             word_sum;
	logic [DataW-1:0] byte_xor;
	logic             high_next;
	int               miss_count  = 0;
	int               check_count = 0;
	int               pending_q   = 0;

	assign mismatches      = miss_count;
	assign results_checked = check_count;
	assign pending         = pending_q;

	function automatic sum_t add_end_around(input sum_t a, input sum_t b);
		logic [SumW:0] full;
		full = {1'b0, a} + {1'b0, b};
		return full[SumW-1:0] + sum_t'(full[SumW]);
	endfunction

	// Fold one byte into the running sum and xor; on the last byte queue the checksum
	task automatic absorb_byte(input logic [DataW-1:0] data, input logic last);
		sum_t      total;
		checksum_t want;
		total     = add_end_around(word_sum, high_next ? {~data, 8'h00} : {8'h00, ~data});
		word_sum  = total;
		byte_xor  = byte_xor ^ data;
		high_next = !high_next;
		if (last) begin
			// odd length: close the open word with a zero low byte
			if (!high_next)
				total = add_end_around(total, PAD_LOW);
			case (mode)
				MODE_SUM16: want = '{value: total, bytes: SIZE_SUM16};
				MODE_XOR8:  want = '{value: {8'h00, byte_xor}, bytes: SIZE_XOR8};
				default:    want = '{value: '0, bytes: SIZE_NONE};
			endcase
			expected_checksums.push_back(want);
			word_sum  = '0;
			byte_xor  = '0;
			high_next = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		checksum_t got;
		checksum_t want;
		if (!arst_n) begin
			mode      = MODE_NONE;
			word_sum  = '0;
			byte_xor  = '0;
			high_next = 1'b1;
			expected_checksums.delete();
			pending_q <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got = '{value: result_ch.checksum_value, bytes: result_ch.checksum_bytes};
				if (expected_checksums.size() == 0) begin
					miss_count++;
					if (miss_count <= MaxReports)
						$display("%0t: unexpected checksum %h (%0d bytes)",
							$time, got.value, got.bytes);
				end else begin
					want = expected_checksums.pop_front();
					check_count++;
					if (got.value !== want.value || got.bytes !== want.bytes) begin
						miss_count++;
						if (miss_count <= MaxReports)
							$display("%0t: checksum mismatch: expected %h (%0d bytes), got %h (%0d bytes)",
								$time, want.value, want.bytes, got.value, got.bytes);
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == REG_MODE_ADDR)
				mode = pwdata[ModeW-1:0];
			if (byte_ch.valid && byte_ch.ready)
				absorb_byte(byte_ch.data_byte, byte_ch.last_byte);
			pending_q <= expected_checksums.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Top of the checksum unit testbench: clock, reset, byte stream, result stalls
// and mode writes over the register port; the verdict comes from msbc_checker.
// Depends on msbc_pkg, msbc_if, msbc_checker and the unit itself.
module testbench;
	import msbc_pkg::*;

	localparam int               CycleLimit   = 400000;
	localparam int               SettleCycles = 4;
	localparam int               RandomBytes  = 2000;
	localparam logic [ModeW-1:0] ModeUnused   = 2'd3;

	typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} ready_style_t;
	typedef logic [DataW-1:0] msg_t[$];

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [CfgAddrW-1:0] paddr   = '0;
	logic [CfgDataW-1:0] pwdata  = '0;
	logic [CfgDataW-1:0] prdata;
	logic                pready;

	int mismatches;
	int pending;
	int results_checked;

	int           cycle_count   = 0;
	int           burst_left    = 0;
	int           bytes_sent    = 0;
	int           messages_sent = 0;
	int           start_bytes;
	int           phase_left;
	int           len;
	ready_style_t ready_style   = READY_ALWAYS;
	int           style_left    = 0;

	msbc_in_if  byte_ch ();
	msbc_out_if result_ch ();

	mode_select_byte_checksum_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_ch),
		.result_out(result_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	msbc_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_ch        (byte_ch),
		.result_ch      (result_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatches     (mismatches),
		.pending        (pending),
		.results_checked(results_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// Result stalls: pick a new random ready pattern whenever the current one runs out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				ready_style = ready_style_t'($urandom_range(0, 3));
				style_left  = $urandom_range(20, 300);
			end
			style_left--;
			case (ready_style)
				READY_ALWAYS:   result_ch.ready <= 1'b1;
				READY_MOSTLY:   result_ch.ready <= ($urandom_range(0, 3) != 0);
				READY_RARELY:   result_ch.ready <= ($urandom_range(0, 7) == 0);
				READY_PERIODIC: result_ch.ready <= style_left[3];
			endcase
		end
	end

	function automatic logic [DataW-1:0] random_byte();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return DataW'($urandom());
		endcase
	endfunction

	// Send one byte, opening a random gap at the start of each burst
	task automatic send_byte(input logic [DataW-1:0] data, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= data;
		byte_ch.last_byte <= last;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
		if (last)
			messages_sent++;
	endtask

	task automatic send_message(input msg_t msg);
		foreach (msg[i])
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	// Hold the stream until every queued checksum has come out
	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_mode(input logic [ModeW-1:0] mode);
		logic [CfgDataW-1:0] word;
		word             = $urandom();
		word[ModeW-1:0]  = mode;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_MODE_ADDR;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mode out of reset is no checksum
		send_message('{8'hFF});
		wait_drained();
		write_mode(MODE_SUM16);
		send_message('{8'h00});
		send_message('{8'hFF, 8'hFF});
		send_message('{8'h12, 8'h34, 8'h56});
		send_message('{8'h00, 8'h00, 8'h00, 8'h01});
		wait_drained();
		write_mode(MODE_XOR8);
		send_message('{8'hA5, 8'h5A, 8'hFF});
		wait_drained();
		write_mode(ModeUnused);
		send_message('{8'h80, 8'h01});

		// switch mode in the middle of a message
		wait_drained();
		write_mode(MODE_SUM16);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		wait_drained();
		write_mode(MODE_XOR8);
		send_byte(8'hF0, 1'b1);
		send_byte(8'h7F, 1'b0);
		wait_drained();
		write_mode(MODE_SUM16);
		send_byte(8'h80, 1'b1);

		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < RandomBytes) begin
			wait_drained();
			write_mode(ModeW'($urandom_range(0, 3)));
			phase_left = $urandom_range(50, 300);
			while (phase_left > 0) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 64)
				                                  : $urandom_range(1, 10);
				for (int i = 0; i < len; i++)
					send_byte(random_byte(), i == len - 1);
				phase_left -= len;
				if ($urandom_range(0, 15) == 0)
					wait_drained();
			end
			// leave a message open across the next mode write
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3)) send_byte(random_byte(), 1'b0);
		end
		wait_drained();

		$display("Sent %0d bytes in %0d messages over all mode codes,", bytes_sent,
			messages_sent);
		$display("mode writes mid-message included; compared %0d checksums, %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/msbc_pkg.sv
hw/rtl/msbc_if.sv
hw/rtl/mode_select_byte_checksum_unit.sv
tb/sv/msbc_checker.sv
tb/sv/testbench.sv
